>>> src/multilevel_priority_fifo_defines.svh
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_defines
// assertion macros used by the priority queue control module
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH
`define MULTILEVEL_PRIORITY_FIFO_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MLPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MLPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg
// types and constants of the multilevel priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

  localparam int PRIO_W     = 3;
  localparam int PID_W      = 16;
  localparam int OUT_LVL_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // decision of the control unit for one transaction
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    status_e status;
  } mlpq_dec_t;

endpackage

`default_nettype wire

>>> src/mlpq_store.sv
// ----------------------------------------------------------------------------
// mlpq_store
// id storage for all rings, one write or one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_store #(
  parameter int DEPTH  = 80,
  parameter int ADDR_W = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic                       rd_en_i,
  input  wire logic [ADDR_W-1:0]          addr_i,
  input  wire logic [mlpq_pkg::PID_W-1:0] wr_data_i,
  output logic      [mlpq_pkg::PID_W-1:0] rd_data_o
);
  import mlpq_pkg::*;

  logic [PID_W-1:0] mem [DEPTH];
  logic [PID_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/mlpq_ctrl.sv
// ----------------------------------------------------------------------------
// mlpq_ctrl
// per-level ring pointers and counts, level selection and storage address
// ----------------------------------------------------------------------------
`default_nettype none

`include "multilevel_priority_fifo_defines.svh"

module mlpq_ctrl #(
  parameter int MAX_PRIORITY = 4,
  parameter int LEVEL_DEPTH  = 16,
  parameter int LVL_W        = 3,
  parameter int ADDR_W       = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        acc_i,
  input  wire logic                        req_type_i,
  input  wire logic [mlpq_pkg::PRIO_W-1:0] priority_req_i,
  output mlpq_pkg::mlpq_dec_t              dec_o,
  output logic      [LVL_W-1:0]            lvl_o,
  output logic      [ADDR_W-1:0]           addr_o
);
  import mlpq_pkg::*;

  localparam int NUM_LEVELS = MAX_PRIORITY + 1;
  localparam int PTR_W      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1);

  logic [PTR_W-1:0] head_q [NUM_LEVELS];
  logic [PTR_W-1:0] head_d [NUM_LEVELS];
  logic [PTR_W-1:0] tail_q [NUM_LEVELS];
  logic [PTR_W-1:0] tail_d [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q  [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_d  [NUM_LEVELS];

  logic             is_deq;
  logic [LVL_W-1:0] enq_lvl;
  logic             enq_ok;
  logic [LVL_W-1:0] deq_lvl;
  logic             any_ne;
  logic [PTR_W-1:0] slot;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign is_deq  = (req_type_i == REQ_DEQ);
  assign enq_lvl = LVL_W'(priority_req_i);
  // a level above the top one behaves like a full level
  assign enq_ok  = (32'(priority_req_i) <= MAX_PRIORITY) &&
                   (cnt_q[enq_lvl] != CNT_W'(LEVEL_DEPTH));

  // highest non-empty level wins
  always_comb begin
    deq_lvl = '0;
    any_ne  = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_q[i] != '0) begin
        deq_lvl = LVL_W'(i);
        any_ne  = 1'b1;
      end
    end
  end

  always_comb begin
    dec_o.rd_en = acc_i && is_deq && any_ne;
    dec_o.wr_en = acc_i && !is_deq && enq_ok;
    if (is_deq) begin
      dec_o.status = any_ne ? ST_OK : ST_EMPTY;
      lvl_o        = deq_lvl;
      slot         = head_q[deq_lvl];
    end else begin
      dec_o.status = enq_ok ? ST_OK : ST_DROP;
      lvl_o        = enq_lvl;
      slot         = tail_q[enq_lvl];
    end
    addr_o = ADDR_W'(lvl_o) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(slot);
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (dec_o.wr_en) begin
      tail_d[enq_lvl] = ring_next(tail_q[enq_lvl]);
      cnt_d[enq_lvl]  = cnt_q[enq_lvl] + 1'b1;
    end
    if (dec_o.rd_en) begin
      head_d[deq_lvl] = ring_next(head_q[deq_lvl]);
      cnt_d[deq_lvl]  = cnt_q[deq_lvl] - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  `MLPQ_ASSERT_NEXT(a_enq_count_up, dec_o.wr_en,
    cnt_q[$past(enq_lvl)] == $past(cnt_q[enq_lvl]) + 1'b1, "enqueue did not grow its level")

  `MLPQ_ASSERT_NEXT(a_deq_count_down, dec_o.rd_en,
    cnt_q[$past(deq_lvl)] == $past(cnt_q[deq_lvl]) - 1'b1, "dequeue did not shrink its level")

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
    `MLPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q[g] <= CNT_W'(LEVEL_DEPTH),
      "level count above ring depth")
  end

endmodule

`default_nettype wire

>>> src/multilevel_priority_fifo.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo
// strict-priority ready queue with one id ring per priority level
// ----------------------------------------------------------------------------
// usage
//   slave stream: s_axis_tuser selects the request (0 enqueue, 1 dequeue),
//   s_axis_tdata carries the level and the process id of an enqueue.
//   master stream: one result transaction per request, s_axis_tuser-style
//   status in m_axis_tuser (ok, enqueue dropped, nothing to dequeue) and
//   the dequeued id and its level in m_axis_tdata.
//   the result is registered and presented in the cycle after the request
//   is taken. throughput: one request per cycle unless the receiver
//   stalls; the single-port id storage is written by an enqueue or read by
//   a dequeue in the accepting cycle and its registered read data is the id
//   part of the result register. reset empties every level; the id storage
//   itself is not cleared. when the receiver stalls, the result register
//   holds and s_axis_tready stays low until the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_priority_fifo #(
  parameter int MAX_PRIORITY = 4,
  parameter int LEVEL_DEPTH  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [2:0] priority_req, [18:3] pid, [23:19] zero
  input  wire logic [mlpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [15:0] out_pid, [18:16] out_level, [23:19] zero
  output logic      [mlpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic      [mlpq_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import mlpq_pkg::*;

  localparam int NUM_LEVELS = MAX_PRIORITY + 1;
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int STORE_D    = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W     = $clog2(STORE_D);
  localparam int PAD_W      = OUT_DATA_W - PID_W - OUT_LVL_W;

  logic                 accept;
  mlpq_dec_t            dec;
  logic [LVL_W-1:0]     lvl;
  logic [ADDR_W-1:0]    addr;
  logic [PID_W-1:0]     rd_data;

  logic                 valid_q;
  status_e              status_q;
  logic [OUT_LVL_W-1:0] level_q;
  logic                 pid_ok_q;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mlpq_ctrl #(
    .MAX_PRIORITY(MAX_PRIORITY),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .LVL_W       (LVL_W),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (accept),
    .req_type_i    (s_axis_tuser),
    .priority_req_i(s_axis_tdata[PRIO_W-1:0]),
    .dec_o         (dec),
    .lvl_o         (lvl),
    .addr_o        (addr)
  );

  mlpq_store #(
    .DEPTH (STORE_D),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (dec.wr_en),
    .rd_en_i  (dec.rd_en),
    .addr_i   (addr),
    .wr_data_i(s_axis_tdata[PRIO_W +: PID_W]),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= dec.status;
      pid_ok_q <= dec.rd_en;
      level_q  <= dec.rd_en ? OUT_LVL_W'(lvl) : '0;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, level_q, (pid_ok_q ? rd_data : '0)};

endmodule

`default_nettype wire
